// ===== hdl/laplacian_3x3_filter_assert.svh =====
// Assertion macros for the checker file.
`ifndef LAPLACIAN_3X3_FILTER_ASSERT_SVH
`define LAPLACIAN_3X3_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LAP3_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lap3 check failed");

// Next-cycle implication, disabled while in reset.
`define LAP3_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lap3 check failed");

`endif

// ===== hdl/lap3_pkg.sv =====
`timescale 1ns / 1ps
package lap3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
  localparam int OROW_W  = $clog2(MAX_HEIGHT);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
  localparam int LINE_W  = 2 * PIXEL_BITS;
  localparam int SUM_W   = PIXEL_BITS + 3;

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int RESULT_W     = 12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_ADDR  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_ADDR = CFG_ADDR_W'(4);

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // One pending result: interior flag, last flag and the 3x3 neighbourhood.
  typedef struct packed {
    logic                nz;
    logic                last;
    pixel_t [2:0][2:0]   win;
  } lap3_job_t;

endpackage

// ===== hdl/lap3_if.sv =====
`timescale 1ns / 1ps
interface lap3_in_if;
  import lap3_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  pixel_t  pixel;

  modport source (output valid, output action, output pixel, input ready);
  modport sink   (input valid, input action, input pixel, output ready);
endinterface

interface lap3_out_if;
  import lap3_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] filtered;
  logic                       last;

  modport source (output valid, output filtered, output last, input ready);
  modport sink   (input valid, input filtered, input last, output ready);
endinterface

// ===== hdl/lap3_ram.sv =====
`timescale 1ns / 1ps
module lap3_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/lap3_front.sv =====
`timescale 1ns / 1ps
module lap3_front (
  input  logic                             clk,
  input  logic                             rst_n,
  lap3_in_if.sink                          in_ch,
  input  logic [lap3_pkg::CFG_WIDTH_W-1:0]  image_width,
  input  logic [lap3_pkg::CFG_HEIGHT_W-1:0] image_height,
  input  logic [lap3_pkg::QUEUE_CNT_W-1:0]  q_count,
  output logic                             push,
  output lap3_pkg::lap3_job_t              push_job
);
  import lap3_pkg::*;

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [ROW_W-1:0]   height_t;

  function automatic width_t clamp_width(input logic [CFG_WIDTH_W-1:0] v);
    width_t r;
    if (v == '0) begin
      r = width_t'(1);
    end else if (v > CFG_WIDTH_W'(MAX_WIDTH)) begin
      r = width_t'(MAX_WIDTH);
    end else begin
      r = width_t'(v);
    end
    return r;
  endfunction

  function automatic height_t clamp_height(input logic [CFG_HEIGHT_W-1:0] v);
    height_t r;
    if (v == '0) begin
      r = height_t'(1);
    end else if (v > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      r = height_t'(MAX_HEIGHT);
    end else begin
      r = height_t'(v);
    end
    return r;
  endfunction

  // frame position state
  logic              active_r, active_nxt;
  width_t            cur_w_r, cur_w_nxt;
  height_t           cur_h_r, cur_h_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [OROW_W-1:0] orow_r, orow_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;

  // line-store stage
  logic              s1_shift_r, s1_emit_r;
  pixel_t            s1_pix_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_nz_r, s1_last_r;
  logic              byp_r;
  logic [LINE_W-1:0] byp_data_r;
  pixel_t [2:0][2:0] win_r, win_shift, win_nxt;

  logic              accept, is_flush, pix_take, pix_emit, flush_emit, emit;
  width_t            w_eff, col_inc, ocol_inc;
  height_t           h_eff, orow_ext;
  width_t            ocol_ext;
  logic              col_wrap, ocol_wrap, out_nz, out_last;
  logic [LINE_W-1:0] ram_rd_data, line_rd, ram_wr_data;
  pixel_t            up_rd, mid_rd;

  assign in_ch.ready = (q_count + QUEUE_CNT_W'(s1_emit_r)) < QUEUE_CNT_W'(QUEUE_DEPTH);

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_flush = (in_ch.action == ACT_FLUSH);
  assign w_eff    = active_r ? cur_w_r : clamp_width(image_width);
  assign h_eff    = active_r ? cur_h_r : clamp_height(image_height);

  assign pix_take   = accept && !is_flush && (in_row_r < h_eff);
  assign pix_emit   = pix_take && ((in_row_r > ROW_W'(1)) ||
                      ((in_row_r == ROW_W'(1)) && (in_col_r != '0)));
  assign flush_emit = accept && is_flush && active_r && (in_row_r >= cur_h_r);
  assign emit       = pix_emit || flush_emit;

  assign col_inc  = width_t'(in_col_r) + width_t'(1);
  assign col_wrap = (col_inc >= w_eff);
  assign ocol_inc = width_t'(ocol_r) + width_t'(1);
  assign ocol_wrap = (ocol_inc >= w_eff);
  assign orow_ext = height_t'(orow_r);
  assign ocol_ext = width_t'(ocol_r);

  assign out_nz   = (orow_r != '0) && ((orow_ext + height_t'(2)) <= h_eff) &&
                    (ocol_r != '0) && ((ocol_ext + width_t'(2)) <= w_eff);
  assign out_last = (orow_ext == (h_eff - height_t'(1))) &&
                    (ocol_ext == (w_eff - width_t'(1)));

  always_comb begin
    active_nxt = active_r;
    cur_w_nxt  = cur_w_r;
    cur_h_nxt  = cur_h_r;
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    if (accept && !is_flush && !active_r) begin
      active_nxt = 1'b1;
      cur_w_nxt  = w_eff;
      cur_h_nxt  = h_eff;
    end
    if (pix_take) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
    end
    if (emit) begin
      if (out_last) begin
        active_nxt = 1'b0;
        in_row_nxt = '0;
        in_col_nxt = '0;
        orow_nxt   = '0;
        ocol_nxt   = '0;
      end else if (ocol_wrap) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + OROW_W'(1);
      end else begin
        ocol_nxt = ocol_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      cur_w_r    <= '0;
      cur_h_r    <= '0;
      in_row_r   <= '0;
      in_col_r   <= '0;
      orow_r     <= '0;
      ocol_r     <= '0;
      s1_shift_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      byp_r      <= 1'b0;
      win_r      <= '0;
    end else begin
      active_r   <= active_nxt;
      cur_w_r    <= cur_w_nxt;
      cur_h_r    <= cur_h_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      orow_r     <= orow_nxt;
      ocol_r     <= ocol_nxt;
      s1_shift_r <= pix_take;
      s1_emit_r  <= emit;
      byp_r      <= s1_shift_r && pix_take && (s1_col_r == in_col_r);
      win_r      <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r   <= in_ch.pixel;
    s1_col_r   <= in_col_r;
    s1_nz_r    <= out_nz;
    s1_last_r  <= out_last;
    byp_data_r <= ram_wr_data;
  end

  // {upper, middle} per column; read when a pixel is taken, written back the cycle after
  lap3_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_shift_r),
    .wr_addr (s1_col_r),
    .wr_data (ram_wr_data),
    .rd_en   (pix_take),
    .rd_addr (in_col_r),
    .rd_data (ram_rd_data)
  );

  // forward a same-column write from the previous beat
  assign line_rd     = byp_r ? byp_data_r : ram_rd_data;
  assign up_rd       = line_rd[LINE_W-1:PIXEL_BITS];
  assign mid_rd      = line_rd[PIXEL_BITS-1:0];
  assign ram_wr_data = {mid_rd, s1_pix_r};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_shift[i][0] = win_r[i][1];
      win_shift[i][1] = win_r[i][2];
    end
    win_shift[0][2] = up_rd;
    win_shift[1][2] = mid_rd;
    win_shift[2][2] = s1_pix_r;
    win_nxt = s1_shift_r ? win_shift : win_r;
  end

  assign push          = s1_emit_r;
  assign push_job.nz   = s1_nz_r;
  assign push_job.last = s1_last_r;
  assign push_job.win  = win_nxt;

endmodule

// ===== hdl/lap3_queue.sv =====
`timescale 1ns / 1ps
module lap3_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  lap3_pkg::lap3_job_t             push_job,
  input  logic                            pop,
  output lap3_pkg::lap3_job_t             head_job,
  output logic [lap3_pkg::QUEUE_CNT_W-1:0] count
);
  import lap3_pkg::*;

  lap3_job_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    logic [QUEUE_PTR_W-1:0] r;
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QUEUE_PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  assign head_job = slots[rd_ptr_r];
  assign count    = count_r;

endmodule

// ===== hdl/lap3_back.sv =====
`timescale 1ns / 1ps
module lap3_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lap3_pkg::lap3_job_t             head_job,
  input  logic [lap3_pkg::QUEUE_CNT_W-1:0] q_count,
  output logic                            pop,
  lap3_out_if.source                      out_ch
);
  import lap3_pkg::*;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [RESULT_W-1:0] filtered_r;
  logic                       last_r;
  logic [SUM_W-1:0]           nsum, centre8;
  logic [RESULT_W-1:0]        lap;

  assign pop = (q_count != '0) && (!out_valid_r || out_ch.ready);

  always_comb begin
    nsum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!((i == 1) && (j == 1))) begin
          nsum = nsum + SUM_W'(head_job.win[i][j]);
        end
      end
    end
    centre8 = SUM_W'(head_job.win[1][1]) << 3;
    lap     = RESULT_W'(centre8) - RESULT_W'(nsum);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      filtered_r <= head_job.nz ? $signed(lap) : '0;
      last_r     <= head_job.last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = filtered_r;
  assign out_ch.last     = last_r;

endmodule

// ===== hdl/laplacian_3x3_filter.sv =====
`timescale 1ns / 1ps
// Results pass the line-store stage register, the queue and the output register.
// One item per cycle while the queue has room; the line store is read on accept and
// written back the next cycle with same-column forwarding, so no item waits on it.
// Reset (rst_n low, synchronous): frame counters, window, queue and output cleared,
// registers back to 640 x 480; line store contents are not cleared.
module laplacian_3x3_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  lap3_in_if.sink                         in_ch,
  lap3_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lap3_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lap3_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lap3_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import lap3_pkg::*;

  logic [CFG_WIDTH_W-1:0]  image_width_r;
  logic [CFG_HEIGHT_W-1:0] image_height_r;
  logic                    cfg_wr;

  lap3_job_t              push_job, head_job;
  logic                   push, pop;
  logic [QUEUE_CNT_W-1:0] q_count;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        REG_WIDTH_ADDR:  image_width_r  <= cfg_pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT_ADDR: image_height_r <= cfg_pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_WIDTH_ADDR:  cfg_prdata = CFG_DATA_W'(image_width_r);
      REG_HEIGHT_ADDR: cfg_prdata = CFG_DATA_W'(image_height_r);
      default:         cfg_prdata = '0;
    endcase
  end

  lap3_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .q_count      (q_count),
    .push         (push),
    .push_job     (push_job)
  );

  lap3_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .count    (q_count)
  );

  lap3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_count  (q_count),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== hdl/lap3_check.sv =====
`timescale 1ns / 1ps
`include "laplacian_3x3_filter_assert.svh"
module lap3_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [lap3_pkg::RESULT_W-1:0] filtered,
  input logic                                last
);
  import lap3_pkg::*;

  localparam int ResultMax = 8 * ((1 << PIXEL_BITS) - 1);

  // stalled beat holds
  `LAP3_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(filtered) && $stable(last))
  // Laplacian stays within eight full-scale pixels
  `LAP3_ASSERT_IMP(a_range, clk, rst_n, out_valid, (filtered >= -RESULT_W'(ResultMax)) && (filtered <= RESULT_W'(ResultMax)))
  // final pixel is a corner, hence border zero
  `LAP3_ASSERT_IMP(a_last_zero, clk, rst_n, out_valid && last, filtered == '0)
  // no beat straight out of reset
  `LAP3_ASSERT_IMP(a_reset_idle, clk, rst_n, !$past(rst_n), !out_valid)

endmodule

bind laplacian_3x3_filter lap3_check u_lap3_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .filtered  (out_ch.filtered),
  .last      (out_ch.last)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import lap3_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic signed [RESULT_W-1:0] filtered;
    logic                       last;
  } lap_result_t;

  typedef struct packed {
    action_t     act;
    pixel_t      pix;
    logic        typed;
    lap_result_t res;
  } stim_row_t;

  // 3x3 image: idle flush, early flush, bright centre, surplus pixel, drain, flush after drain,
  // then a dark centre in a bright ring (left draining for the next part).
  localparam stim_row_t DIRECTED [26] = '{
    '{ACT_FLUSH, 8'h00, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_FLUSH, 8'h00, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b1, '{12'sd2040, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_FLUSH, 8'h00, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_FLUSH, 8'h00, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_FLUSH, 8'h00, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_FLUSH, 8'h00, 1'b1, '{12'sd0, 1'b1}},
    '{ACT_FLUSH, 8'h00, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b0, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'h00, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b1, '{12'sd0, 1'b0}},
    '{ACT_PIXEL, 8'hFF, 1'b1, '{-12'sd2040, 1'b0}}
  };

  // raw register values, out-of-range ones included
  localparam int unsigned EXT_W [3] = '{0, 5, 0};
  localparam int unsigned EXT_H [3] = '{4, 0, 0};

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  lap3_in_if  in_ch ();
  lap3_out_if out_ch ();

  laplacian_3x3_filter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // filter state as the block should hold it
  logic [CFG_WIDTH_W-1:0]  reg_width  = WIDTH_RESET;
  logic [CFG_HEIGHT_W-1:0] reg_height = HEIGHT_RESET;
  pixel_t upper_mem [MAX_WIDTH];
  pixel_t mid_mem   [MAX_WIDTH];
  pixel_t [2:0][2:0] win = '0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  int unsigned drained = 0;
  int unsigned img_w = 0;
  int unsigned img_h = 0;
  bit img_on = 1'b0;

  lap_result_t laplacian_due [$];
  int unsigned faults = 0;
  int unsigned useful_beats = 0;
  int unsigned quiet = 0;
  bit calm = 1'b0;

  function automatic lap_result_t emit_laplacian();
    int unsigned r, c;
    int acc;
    lap_result_t res;
    r = drained / img_w;
    c = drained % img_w;
    res.filtered = '0;
    if (r >= 1 && r + 2 <= img_h && c >= 1 && c + 2 <= img_w) begin
      acc = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          acc += int'(win[i][j]);
      res.filtered = RESULT_W'(9 * int'(win[1][1]) - acc);
    end
    res.last = (drained + 1 == img_w * img_h);
    drained++;
    if (drained >= img_w * img_h) begin
      img_on  = 1'b0;
      row_pos = 0;
      col_pos = 0;
      drained = 0;
    end
    return res;
  endfunction

  function automatic bit predict_laplacian(input action_t act, input pixel_t pix,
                                           output lap_result_t res, output bit took);
    int unsigned n;
    res  = '0;
    took = 1'b0;
    if (act == ACT_FLUSH) begin
      if (img_on && row_pos >= img_h && drained < img_w * img_h) begin
        took = 1'b1;
        res  = emit_laplacian();
        return 1'b1;
      end
      return 1'b0;
    end
    if (!img_on) begin
      img_w   = (reg_width == 0) ? 1 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
      img_h   = (reg_height == 0) ? 1 : (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
      row_pos = 0;
      col_pos = 0;
      drained = 0;
      img_on  = 1'b1;
    end
    if (row_pos >= img_h || col_pos >= img_w)
      return 1'b0;
    took = 1'b1;
    n = row_pos * img_w + col_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_mem[col_pos];
    win[1][2] = mid_mem[col_pos];
    win[2][2] = pix;
    upper_mem[col_pos] = mid_mem[col_pos];
    mid_mem[col_pos]   = pix;
    col_pos++;
    if (col_pos >= img_w) begin
      col_pos = 0;
      row_pos++;
    end
    if (n >= img_w + 1 && drained < img_w * img_h) begin
      res = emit_laplacian();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == REG_WIDTH_ADDR) reg_width = data[CFG_WIDTH_W-1:0];
    else reg_height = data[CFG_HEIGHT_W-1:0];
    want = (addr == REG_WIDTH_ADDR) ? CFG_DATA_W'(reg_width) : CFG_DATA_W'(reg_height);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      $error("%s readback: expected %0d, got %0d",
             (addr == REG_WIDTH_ADDR) ? "image_width" : "image_height", want, cfg_prdata);
      faults++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    reg_write(REG_WIDTH_ADDR, CFG_DATA_W'(w));
    reg_write(REG_HEIGHT_ADDR, CFG_DATA_W'(h));
  endtask

  // holds valid until the beat goes through, then books its result
  task automatic send_beat(input action_t act, input pixel_t pix, input bit typed,
                           input lap_result_t typed_res);
    lap_result_t res;
    bit has, took;
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.pixel  <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = predict_laplacian(act, pix, res, took);
    if (typed) begin
      has = 1'b1;
      res = typed_res;
    end
    if (has) laplacian_due.push_back(res);
    if (took) useful_beats++;
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // mostly pixels until the image is in, then mostly flushes; the odd beat goes the wrong way
  task automatic random_beat();
    action_t act;
    pixel_t pix;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    pix = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : pixel_t'($urandom_range(0, 255));
    if (!img_on || row_pos < img_h) act = ($urandom_range(0, 11) == 0) ? ACT_FLUSH : ACT_PIXEL;
    else act = ($urandom_range(0, 11) == 0) ? ACT_PIXEL : ACT_FLUSH;
    idle_gap();
    send_beat(act, pix, 1'b0, '0);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (laplacian_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned n, sel, w, h;
    foreach (upper_mem[i]) begin
      upper_mem[i] = '0;
      mid_mem[i]   = '0;
    end
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_PIXEL;
    in_ch.pixel  = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_size(3, 3);
    foreach (DIRECTED[k]) begin
      idle_gap();
      send_beat(DIRECTED[k].act, DIRECTED[k].pix, DIRECTED[k].typed, DIRECTED[k].res);
    end

    // first new size written mid-image: the draining image keeps its own
    foreach (EXT_W[k]) begin
      settle();
      set_size(EXT_W[k], EXT_H[k]);
      while (img_on) random_beat();
      while (!img_on) random_beat();
      while (img_on) random_beat();
    end

    useful_beats = 0;
    while (useful_beats < 700) begin
      settle();
      sel = $urandom_range(0, 7);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
      if (sel <= 3) set_size(w, h);
      else if (sel == 4) reg_write(REG_WIDTH_ADDR, CFG_DATA_W'(w));
      else if (sel == 5) reg_write(REG_HEIGHT_ADDR, CFG_DATA_W'(h));
      n = $urandom_range(10, 90);
      repeat (n) random_beat();
      calm = (useful_beats >= 600);
    end

    in_ch.valid <= 1'b0;
    while (laplacian_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : result_side
    int unsigned stall, seen;
    bit held;
    lap_result_t want;
    stall = 0;
    seen  = 0;
    held  = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        seen++;
        if (laplacian_due.size() == 0) begin
          $error("unexpected beat: filtered %0d, last %0b", out_ch.filtered, out_ch.last);
          faults++;
        end else begin
          want = laplacian_due.pop_front();
          if (out_ch.filtered !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, out_ch.filtered);
            faults++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            faults++;
          end
        end
      end
      // one long hold-off so the input side backs up
      if (seen == 150 && !held) begin
        held  = 1'b1;
        stall = 400;
      end else if (stall == 0 && !calm && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 17);
      end
      if (stall != 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
